### rtl/life_automaton_with_aging_assert.svh
// Assertion macros used by the Life engine controller.
`ifndef LIFE_AUTOMATON_WITH_AGING_ASSERT_SVH
`define LIFE_AUTOMATON_WITH_AGING_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LAA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LAA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

### rtl/laa_pkg.sv
// Shared types and constants of the Life engine.
`default_nettype none
package laa_pkg;
    localparam int COLUMNS_DEF = 256;
    localparam int ROWS_DEF    = 32;
    localparam logic [2:0] AGE_LIMIT_RST = 3'd4;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACCESS, S_RDWAIT,
        S_GEN_RD, S_GEN_WAIT, S_GEN_CALC, S_GEN_WR, S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clr_start;   // reset the sweep counters
        logic       clr_write;   // write zero to the other plane at the sweep cell, swap planes
        logic       load_item;   // capture the input beat
        logic       item_write;  // write the captured cell
        logic       item_read;   // issue a read of the captured cell
        logic       cap_read;    // capture the read data into the result
        logic       clear_res;   // result read value to zero
        logic       gen_start;   // reset sweep counters for a generation
        logic       gen_read;    // read neighbour tap k
        logic       gen_acc;     // accumulate the tap read in the previous cycle
        logic       gen_write;   // write the next value and step the sweep
        logic       flip;        // swap the current plane
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;  // sweep counter at its last cell
        logic tap_last;    // tap counter at its last tap
        logic is_write;
        logic is_read;
        logic is_advance;
    } t_stat;
endpackage
`default_nettype wire

### rtl/laa_datapath.sv
// Datapath of the Life engine: cell planes, sweep counters and the rule.
`default_nettype none
module laa_datapath import laa_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_stat           o_stat,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_col,
    input  wire logic [4:0] i_row,
    input  wire logic [3:0] i_cell_value,
    input  wire logic [2:0] i_age_limit,
    output logic      [3:0] o_read_value,
    output logic            o_plane
);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = CW + RW + 1;
    localparam int DEPTH = 2 * COLUMNS * ROWS;

    logic [3:0] r_mem [DEPTH];
    logic [3:0] r_rdata;

    logic [1:0]    r_op;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [3:0]    r_val;
    logic [CW-1:0] r_sx, n_sx;
    logic [RW-1:0] r_sy, n_sy;
    logic [3:0]    r_tap;
    logic [3:0]    r_cnt;
    logic [3:0]    r_self;
    logic [3:0]    r_tap_d;
    logic          r_plane;
    logic [3:0]    r_res;

    logic [CW-1:0] tx;
    logic [RW-1:0] ty;
    logic [AW-1:0] raddr, waddr;
    logic [3:0]    wdata, nextv;
    logic          we, re;

    // Taps 0..7 are neighbours, tap 8 is the cell itself.
    always_comb begin
        tx = r_sx;
        ty = r_sy;
        case (r_tap)
            4'd0: begin tx = r_sx - 1'b1; ty = r_sy - 1'b1; end
            4'd1: begin ty = r_sy - 1'b1; end
            4'd2: begin tx = r_sx + 1'b1; ty = r_sy - 1'b1; end
            4'd3: begin tx = r_sx - 1'b1; end
            4'd4: begin tx = r_sx + 1'b1; end
            4'd5: begin tx = r_sx - 1'b1; ty = r_sy + 1'b1; end
            4'd6: begin ty = r_sy + 1'b1; end
            4'd7: begin tx = r_sx + 1'b1; ty = r_sy + 1'b1; end
            default: ;
        endcase
    end

    always_comb begin
        nextv = r_self;
        if (!r_self[3] && r_self != 4'd0) begin
            if (r_cnt < 4'd2 || r_cnt > 4'd3) nextv = 4'd0;
            else if (r_self[2:0] < i_age_limit) nextv = r_self + 4'd1;
        end else if (r_self == 4'd0 && r_cnt == 4'd3) begin
            nextv = 4'd1;
        end
    end

    always_comb begin
        re    = i_cmd.item_read | i_cmd.gen_read;
        raddr = i_cmd.gen_read ? {r_plane, ty, tx} : {r_plane, r_row, r_col};
        we    = i_cmd.clr_write | i_cmd.item_write | i_cmd.gen_write;
        waddr = {r_plane, r_row, r_col};
        wdata = r_val;
        if (i_cmd.gen_write) begin
            waddr = {~r_plane, r_sy, r_sx};
            wdata = nextv;
        end else if (i_cmd.clr_write) begin
            waddr = {~r_plane, r_sy, r_sx};
            wdata = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rdata <= r_mem[raddr];
    end

    always_comb begin
        {n_sy, n_sx} = {r_sy, r_sx} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= 1'b0;
            r_sx <= '0;
            r_sy <= '0;
            r_tap <= '0;
            r_cnt <= '0;
            r_res <= '0;
            // The first tap of a cell has no read behind it; pointing at the
            // self tap keeps that slot from counting a neighbour.
            r_tap_d <= 4'd8;
        end else begin
            // Clearing alternates planes: write plane1 while current is 0.
            if (i_cmd.clr_start || i_cmd.gen_start) begin
                r_sx <= '0; r_sy <= '0; r_tap <= '0; r_cnt <= '0;
            end
            if (i_cmd.clr_write) begin
                r_plane <= ~r_plane;
                if (r_plane) begin r_sx <= n_sx; r_sy <= n_sy; end
            end
            if (i_cmd.gen_read) r_tap_d <= r_tap;
            if (i_cmd.gen_read && r_tap != 4'd8) r_tap <= r_tap + 4'd1;
            if (i_cmd.gen_acc) begin
                if (r_tap_d == 4'd8) r_self <= r_rdata;
                else if (!r_rdata[3] && r_rdata != 4'd0) r_cnt <= r_cnt + 4'd1;
            end
            if (i_cmd.gen_write) begin
                r_sx <= n_sx; r_sy <= n_sy; r_tap <= '0; r_cnt <= '0;
            end
            if (i_cmd.flip) r_plane <= ~r_plane;
            if (i_cmd.clear_res) r_res <= '0;
            if (i_cmd.cap_read) r_res <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_operation;
            r_col <= i_col[CW-1:0];
            r_row <= i_row[RW-1:0];
            r_val <= i_cell_value;
        end
    end

    always_comb begin
        o_stat.sweep_last = (r_sx == CW'(COLUMNS - 1)) && (r_sy == RW'(ROWS - 1));
        o_stat.tap_last   = (r_tap == 4'd8);
        o_stat.is_write   = (r_op == OP_WRITE);
        o_stat.is_read    = (r_op == OP_READ);
        o_stat.is_advance = (r_op == OP_ADVANCE);
    end

    assign o_read_value = r_res;
    assign o_plane      = r_plane;
endmodule
`default_nettype wire

### rtl/laa_control.sv
// Controller state machine of the Life engine.
`default_nettype none
`include "life_automaton_with_aging_assert.svh"
module laa_control import laa_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    input  wire logic  i_in_fire,
    input  wire logic  i_out_ready,
    output t_cmd       o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);
    t_state r_state, n_state;
    logic   r_plane_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_plane_odd <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_plane_odd <= ~r_plane_odd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_plane_odd && i_stat.sweep_last) n_state = S_IDLE;
            S_IDLE:     if (i_in_fire) n_state = S_ACCESS;
            S_ACCESS:   n_state = i_stat.is_read ? S_RDWAIT :
                                  i_stat.is_advance ? S_GEN_RD : S_OUT;
            S_RDWAIT:   n_state = S_OUT;
            S_GEN_RD:   n_state = i_stat.tap_last ? S_GEN_WAIT : S_GEN_RD;
            S_GEN_WAIT: n_state = S_GEN_CALC;
            S_GEN_CALC: n_state = S_GEN_WR;
            S_GEN_WR:   n_state = i_stat.sweep_last ? S_OUT : S_GEN_RD;
            S_OUT:      if (i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_write = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_item = i_in_fire;
                o_cmd.clear_res = i_in_fire;
                o_cmd.gen_start = i_in_fire;
            end
            S_ACCESS: begin
                o_cmd.item_write = i_stat.is_write;
                o_cmd.item_read  = i_stat.is_read;
            end
            S_RDWAIT: o_cmd.cap_read = 1'b1;
            S_GEN_RD: begin
                o_cmd.gen_read = 1'b1;
                o_cmd.gen_acc  = 1'b1;
            end
            S_GEN_WAIT: o_cmd.gen_acc = 1'b1;
            S_GEN_CALC: ;
            S_GEN_WR: begin
                o_cmd.gen_write = 1'b1;
                o_cmd.flip = i_stat.sweep_last;
            end
            S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    `LAA_ASSERT_IMP(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `LAA_ASSERT_NEXT(a_fire_leaves_idle, i_clk, i_rst_n, i_in_fire && o_in_ready,
        r_state == S_ACCESS)
    `LAA_ASSERT_IMP(a_one_write, i_clk, i_rst_n, o_cmd.gen_write,
        !o_cmd.item_write && !o_cmd.clr_write)
endmodule
`default_nettype wire

### rtl/life_automaton_with_aging.sv
// Top level of the toroidal Life engine with cell aging.
//
//  channel   direction  contents
//  s_axis    in         tdata: operation[1:0] col[9:2] row[14:10] cell_value[18:15]
//  m_axis    out        tdata: read_value[3:0] plane[4]
//  cfg       in         age_limit, 3 bits
//
// A write or an unused code passes through S_ACCESS to S_OUT; a read also waits in S_RDWAIT.
// An advance sweeps every cell: per cell nine memory reads, one per tap on the
// single read port, then S_GEN_WAIT, S_GEN_CALC and the write in S_GEN_WR.
// After reset a clearing pass writes zero to both planes, during which no
// beat is accepted.
// One item is in work at a time; the result register holds while stalled.
`default_nettype none
module life_automaton_with_aging import laa_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // operation, col, row, cell_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,  // read_value, plane
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata
);
    t_cmd  cmd;
    t_stat stat;
    logic [2:0] r_age_limit;
    logic [3:0] read_value;
    logic       plane;
    logic       in_fire;

    // The age limit register takes any write; only idle writes are expected.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_age_limit <= AGE_LIMIT_RST;
        else if (i_cfg_we) r_age_limit <= i_cfg_wdata;
    end

    assign in_fire = s_axis_tvalid & s_axis_tready;

    laa_control u_control (
        .i_clk, .i_rst_n, .i_stat(stat), .i_in_fire(in_fire),
        .i_out_ready(m_axis_tready), .o_cmd(cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    laa_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_datapath (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_operation(s_axis_tdata[1:0]), .i_col(s_axis_tdata[9:2]),
        .i_row(s_axis_tdata[14:10]), .i_cell_value(s_axis_tdata[18:15]),
        .i_age_limit(r_age_limit), .o_read_value(read_value), .o_plane(plane)
    );

    assign m_axis_tdata = {3'd0, plane, read_value};
endmodule
`default_nettype wire

### tb/sv/life_grid_checker.sv
// Checker for the Life engine: watches both streams and the config port and scores the results.
`default_nettype none
module life_grid_checker import laa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [23:0] i_in_data,   // operation, col, row, cell_value
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_out_data,  // read_value, plane
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] read_value;
        logic       plane;
    } t_cell_result;

    logic [3:0]   cells [2][ROWS_DEF][COLUMNS_DEF];
    logic         live_plane;
    logic [2:0]   age_cap;
    t_cell_result result_q [$];
    int           mismatches;

    function automatic bit is_live(logic [3:0] v);
        return !v[3] && (v != 4'd0);
    endfunction

    // Next generation from the current plane into the other one.
    task automatic step_generation();
        logic       src;
        logic [3:0] v;
        int         n;
        src = live_plane;
        for (int y = 0; y < ROWS_DEF; y++) begin
            for (int x = 0; x < COLUMNS_DEF; x++) begin
                n = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if ((dx != 0 || dy != 0) &&
                            is_live(cells[src][(y + dy + ROWS_DEF) % ROWS_DEF]
                                               [(x + dx + COLUMNS_DEF) % COLUMNS_DEF]))
                            n++;
                    end
                end
                v = cells[src][y][x];
                if (is_live(v)) begin
                    if (n < 2 || n > 3)
                        v = 4'd0;
                    else if (v[2:0] < age_cap)
                        v = v + 4'd1;
                end else if (v == 4'd0 && n == 3) begin
                    v = 4'd1;
                end
                cells[!src][y][x] = v;
            end
        end
        live_plane = !src;
    endtask

    task automatic note_mismatch(string what, int exp_v, int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_cell_result exp_r;
        t_cell_result act_r;
        logic [1:0]   op;
        logic [7:0]   col;
        logic [4:0]   row;
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++)
                for (int y = 0; y < ROWS_DEF; y++)
                    for (int x = 0; x < COLUMNS_DEF; x++)
                        cells[p][y][x] = 4'd0;
            live_plane = 1'b0;
            age_cap    = AGE_LIMIT_RST;
            result_q.delete();
        end else begin
            if (i_cfg_we)
                age_cap = i_cfg_wdata;
            // Result beats are compared in order against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                act_r = '{read_value: i_out_data[3:0], plane: i_out_data[4]};
                if (result_q.size() == 0) begin
                    note_mismatch("unexpected result beat", 0, act_r);
                end else begin
                    exp_r = result_q.pop_front();
                    if (act_r.read_value !== exp_r.read_value)
                        note_mismatch("read_value", $signed(exp_r.read_value),
                                      $signed(act_r.read_value));
                    if (act_r.plane !== exp_r.plane)
                        note_mismatch("plane", exp_r.plane, act_r.plane);
                end
            end
            if (i_in_valid && i_in_ready) begin
                op  = i_in_data[1:0];
                col = i_in_data[9:2];
                row = i_in_data[14:10];
                exp_r.read_value = 4'd0;
                case (op)
                    OP_WRITE:   cells[live_plane][row][col] = i_in_data[18:15];
                    OP_READ:    exp_r.read_value = cells[live_plane][row][col];
                    OP_ADVANCE: step_generation();
                    default: ;
                endcase
                exp_r.plane = live_plane;
                result_q.push_back(exp_r);
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= mismatches;
    end

    initial begin
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end
endmodule
`default_nettype wire

### tb/sv/tb_life_automaton_with_aging.sv
// Testbench top for the Life engine: clock, reset, stimulus and the final verdict.
`default_nettype none
module tb_life_automaton_with_aging;
    import laa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;  // operation[1:0] col[9:2] row[14:10] cell_value[18:15]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;  // read_value[3:0] plane[4]
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    int          fail_count;
    int          pending;
    int          result_beats;
    int          sent_items;

    life_automaton_with_aging dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    life_grid_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run has five advances plus the clearing pass; the timeout leaves a wide margin for stalls.
    initial begin
        #40ms;
        $display("FAIL life_automaton_with_aging");
        $finish;
    end

    // Result side: random stalls, one long hold-off early on so that the
    // engine keeps a finished result and stops taking input beats, and a
    // stretch with tready held high.
    initial begin
        int hold_cycles;
        m_axis_tready = 1'b0;
        result_beats  = 0;
        hold_cycles   = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                result_beats++;
            if (result_beats == 5 && hold_cycles < 400) begin
                hold_cycles++;
                m_axis_tready <= 1'b0;
            end else if (result_beats >= 40 && result_beats < 75) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Offer one item and return at the edge where it is taken. tvalid is
    // left high so that a following item can go out back to back.
    task automatic send_item(logic [1:0] op, logic [7:0] col, logic [4:0] row,
                             logic [3:0] value);
        bit idle_ok;
        idle_ok = !(sent_items >= 60 && sent_items < 90);
        if (idle_ok && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, value, row, col, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // Wait until every result is back; the engine is then idle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_age_limit(logic [2:0] limit);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random items, mostly writes and reads packed into a small corner so
    // that patterns form and evolve; one advance per phase.
    task automatic random_phase(int count);
        int          advance_at;
        int          pick;
        logic [7:0]  col;
        logic [4:0]  row;
        logic [3:0]  value;
        advance_at = $urandom_range(count / 2, count - 3);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 70) begin
                col = $urandom_range(0, 11);
                row = $urandom_range(0, 7);
            end else begin
                col = $urandom_range(0, 255);
                row = $urandom_range(0, 31);
            end
            // Mostly young live cells, with dead, blocked and any other pattern.
            if ($urandom_range(0, 99) < 60)
                value = $urandom_range(1, 3);
            else
                value = $urandom_range(0, 15);
            if (k == advance_at)
                send_item(OP_ADVANCE, $urandom_range(0, 255), $urandom_range(0, 31),
                          $urandom_range(0, 15));
            else if (pick < 55)
                send_item(OP_WRITE, col, row, value);
            else if (pick < 93)
                send_item(OP_READ, col, row, value);
            else
                send_item(2'd3, col, row, value);
            if (k == 10 && count > 20)
                drain_results();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        sent_items    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a blinker, a still block that ages, blocked cells at the grid
        // corners, two live corner cells that die, and the unused code.
        send_item(OP_WRITE, 8'd10, 5'd5, 4'd1);
        send_item(OP_WRITE, 8'd11, 5'd5, 4'd1);
        send_item(OP_WRITE, 8'd12, 5'd5, 4'd1);
        send_item(OP_WRITE, 8'd100, 5'd10, 4'd3);
        send_item(OP_WRITE, 8'd101, 5'd10, 4'd3);
        send_item(OP_WRITE, 8'd100, 5'd11, 4'd3);
        send_item(OP_WRITE, 8'd101, 5'd11, 4'd7);
        send_item(OP_WRITE, 8'd255, 5'd31, 4'b1000);
        send_item(OP_WRITE, 8'd0, 5'd31, 4'b1111);
        send_item(OP_WRITE, 8'd255, 5'd0, 4'd7);
        send_item(OP_WRITE, 8'd0, 5'd0, 4'd1);
        send_item(OP_READ, 8'd255, 5'd31, 4'd0);
        send_item(OP_READ, 8'd0, 5'd31, 4'd0);
        send_item(2'd3, 8'd255, 5'd31, 4'b1111);
        send_item(OP_ADVANCE, 8'd0, 5'd0, 4'd0);
        send_item(OP_READ, 8'd11, 5'd4, 4'd0);
        send_item(OP_READ, 8'd11, 5'd5, 4'd0);
        send_item(OP_READ, 8'd101, 5'd11, 4'd0);
        send_item(OP_READ, 8'd255, 5'd0, 4'd0);
        send_item(OP_READ, 8'd0, 5'd31, 4'd0);
        set_age_limit(3'd7);
        send_item(OP_ADVANCE, 8'd255, 5'd31, 4'd15);
        send_item(OP_READ, 8'd100, 5'd10, 4'd0);
        send_item(OP_READ, 8'd10, 5'd5, 4'd0);

        // Random part in phases, each under its own age limit.
        set_age_limit(3'd0);
        random_phase(30);
        set_age_limit(3'd1);
        random_phase(30);
        set_age_limit(3'd3);
        random_phase(30);

        drain_results();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS life_automaton_with_aging");
        else
            $display("FAIL life_automaton_with_aging");
        $finish;
    end
endmodule
`default_nettype wire
